FILE: hdl/i64dec_pkg.sv
// Package for the signed integer to decimal text core.
// Holds widths, character codes and the queue word type shared by all modules.
// No dependencies.
package i64dec_pkg;

   // width of the port and of the converted integer
   localparam int IN_BITS       = 64;
   localparam int VALUE_BITS    = 64;

   // shift-and-add-3 conversion: bits taken per cycle, padded width, steps
   localparam int BITS_PER_STEP = 4;
   localparam int STEPS         = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int PAD_BITS      = STEPS * BITS_PER_STEP;
   localparam int STEP_W        = $clog2(STEPS);

   // decimal digits needed for the largest magnitude (log10(2) ~ 0.30103)
   localparam int DIGITS        = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BCD_BITS      = DIGITS * 4;
   localparam int DIGIT_W       = $clog2(DIGITS);

   // queue between front and back
   localparam int QUEUE_DEPTH   = 2;
   localparam int PTR_W         = $clog2(QUEUE_DEPTH);

   // result character codes
   localparam int CHAR_W        = 6;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

   // classified word carried from front to back
   typedef struct packed {
      logic                  neg;
      logic [VALUE_BITS-1:0] mag;
   } item_type;

endpackage

FILE: hdl/i64dec_front.sv
// Front end: takes input words, splits sign and unsigned magnitude.
// Depends on i64dec_pkg.
module i64dec_front (
   input  logic signed [i64dec_pkg::IN_BITS-1:0] req_value,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  q_full,
   output logic                                  q_push,
   output i64dec_pkg::item_type                  q_item
);
   import i64dec_pkg::*;

   logic [VALUE_BITS-1:0] x;

   // low bits only; most negative value keeps its exact unsigned magnitude
   assign x          = req_value[VALUE_BITS-1:0];
   assign q_item.neg = x[VALUE_BITS-1];
   assign q_item.mag = x[VALUE_BITS-1] ? (~x + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : x;

   // handshake straight onto the queue
   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

endmodule

FILE: hdl/i64dec_queue.sv
// Short queue of classified words between front and back.
// Depends on i64dec_pkg.
module i64dec_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  i64dec_pkg::item_type push_item,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output i64dec_pkg::item_type pop_item
);
   import i64dec_pkg::*;

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff,  count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hdl/i64dec_back.sv
// Back end: binary to BCD by shift-and-add-3, leading digit scan, and
// character emission into the result register. Depends on i64dec_pkg.
module i64dec_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  i64dec_pkg::item_type         q_item,
   output logic                         q_pop,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [i64dec_pkg::CHAR_W-1:0] rsp_char_code,
   output logic                         rsp_last
);
   import i64dec_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_DIGIT = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [STEP_W-1:0]   step_ff,  step_in;
   logic [DIGIT_W-1:0]  idx_ff,   idx_in;
   logic                neg_ff,   neg_in;
   logic [PAD_BITS-1:0] sr_ff,    sr_in;
   logic [BCD_BITS-1:0] bcd_ff,   bcd_in;
   logic                out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]   out_char_ff,  out_char_in;
   logic                out_last_ff,  out_last_in;

   logic [PAD_BITS-1:0] sr_step;
   logic [BCD_BITS-1:0] bcd_step;
   logic [DIGIT_W-1:0]  lead;
   logic [3:0]          cur_digit;
   logic                out_free;

   assign rsp_empty     = !out_valid_ff;
   assign rsp_char_code = out_char_ff;
   assign rsp_last      = out_last_ff;
   assign out_free      = !out_valid_ff || rsp_pop;
   assign q_pop         = (state_ff == ST_IDLE) && q_valid;
   assign cur_digit     = bcd_ff[idx_ff*4 +: 4];

   // one cycle of conversion: four shift-and-add-3 steps
   always_comb begin
      bcd_step = bcd_ff;
      sr_step  = sr_ff;
      for (int b = 0; b < BITS_PER_STEP; b++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (bcd_step[d*4 +: 4] >= 4'd5) begin
               bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
            end
         end
         bcd_step = {bcd_step[BCD_BITS-2:0], sr_step[PAD_BITS-1]};
         sr_step  = {sr_step[PAD_BITS-2:0], 1'b0};
      end
   end

   // most significant non-zero digit, digit 0 when the value is zero
   always_comb begin
      lead = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            lead = DIGIT_W'(i);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      sr_in        = sr_ff;
      bcd_in       = bcd_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               neg_in   = q_item.neg;
               sr_in    = PAD_BITS'(q_item.mag);
               bcd_in   = '0;
               step_in  = STEP_W'(STEPS - 1);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            sr_in  = sr_step;
            bcd_in = bcd_step;
            if (step_ff == '0) begin
               state_in = ST_SCAN;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_SCAN: begin
            idx_in   = lead;
            state_in = neg_ff ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = CH_MINUS;
               out_last_in  = 1'b0;
               state_in     = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = CH_ZERO + {2'b00, cur_digit};
               out_last_in  = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      neg_ff      <= neg_in;
      sr_ff       <= sr_in;
      bcd_ff      <= bcd_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

endmodule

FILE: hdl/int64_to_decimal_ascii_core.sv
// Top level: signed integer to decimal ASCII text, one character per word.
// Depends on i64dec_pkg, i64dec_front, i64dec_queue, i64dec_back.
//
//   channel   ports                          direction  moves
//   request   req_push req_full req_value    in         one integer per word
//   response  rsp_pop rsp_empty rsp_char_code out        one character per word
//             rsp_last
//
// Each integer leaves the queue, runs through the shift-and-add-3 converter and
// the leading digit scan, then gives one character per cycle (1 to 20 in all)
// while the response side keeps popping.
// The two-word queue keeps accepting while the back end is busy.
// Reset is synchronous and clears the queue and the sequencer.
// A stalled response holds the back end; the front stalls only on a full queue.
module int64_to_decimal_ascii_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [i64dec_pkg::IN_BITS-1:0] req_value,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [i64dec_pkg::CHAR_W-1:0]         rsp_char_code,
   output logic                                  rsp_last
);
   import i64dec_pkg::*;

   item_type push_item, pop_item;
   logic     q_push, q_full, q_pop, q_valid;

   i64dec_front u_front (
      .req_value (req_value),
      .req_push  (req_push),
      .req_full  (req_full),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   i64dec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_item  (pop_item)
   );

   i64dec_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (pop_item),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule

FILE: tb/sv/i64dec_text_sb_pkg.sv
// Scoreboard for the signed integer to decimal text core.
// Predicts the character words of each accepted integer and checks the popped ones.
// Depends on i64dec_pkg.
package i64dec_text_sb_pkg;

   import i64dec_pkg::*;

   // one expected character word
   typedef struct {
      logic [CHAR_W-1:0] code;
      logic              last;
   } text_char_type;

   class value_text_sb_type;
      text_char_type pending_chars[$];
      int            values_seen;
      int            chars_checked;
      int            faults;

      function new();
         values_seen   = 0;
         chars_checked = 0;
         faults        = 0;
      endfunction

      function int pending();
         return pending_chars.size();
      endfunction

      // turn one accepted integer into its expected characters, most significant first
      function void note_value(logic [IN_BITS-1:0] value);
         logic [VALUE_BITS-1:0] bits;
         logic [VALUE_BITS-1:0] mag;
         logic                  neg;
         logic [3:0]            digits[$];
         text_char_type         ch;
         bits = value[VALUE_BITS-1:0];
         neg  = bits[VALUE_BITS-1];
         // magnitude as unsigned, so the most negative value stays exact
         mag  = neg ? (~bits + 1'b1) : bits;
         do begin
            digits.push_front(4'(mag % 10));
            mag = mag / 10;
         end while (mag != 0 && digits.size() < 19);
         if (neg) begin
            ch.code = CH_MINUS;
            ch.last = 1'b0;
            pending_chars.push_back(ch);
         end
         foreach (digits[i]) begin
            ch.code = CH_ZERO + CHAR_W'(digits[i]);
            ch.last = (i == digits.size() - 1);
            pending_chars.push_back(ch);
         end
         values_seen++;
      endfunction

      // compare one popped word with the oldest expected character
      function void check_char(logic [CHAR_W-1:0] code, logic last, longint unsigned t);
         text_char_type want;
         if (pending_chars.size() == 0) begin
            $display("%0t: character word with nothing expected: code %0d last %0b",
                     t, code, last);
            faults++;
            return;
         end
         want = pending_chars.pop_front();
         chars_checked++;
         if (code !== want.code) begin
            $display("%0t: char_code mismatch: expected %0d actual %0d", t, want.code, code);
            faults++;
         end
         if (last !== want.last) begin
            $display("%0t: last mismatch: expected %0b actual %0b", t, want.last, last);
            faults++;
         end
      endfunction
   endclass

endpackage

FILE: tb/sv/tb.sv
// Testbench top for int64_to_decimal_ascii_core.
// Directed corner integers, then shaped random ones, with random idling on both sides.
// Depends on i64dec_pkg, i64dec_text_sb_pkg and the core RTL.
module tb;

   import i64dec_pkg::*;
   import i64dec_text_sb_pkg::*;

   localparam int N_RANDOM   = 290;
   localparam int CYC_LIMIT  = 200000;
   localparam int HOLD_CYCS  = 300;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push;
   logic                       req_full;
   logic signed [IN_BITS-1:0]  req_value;
   logic                       rsp_empty;
   logic                       rsp_pop;
   logic [CHAR_W-1:0]          rsp_char_code;
   logic                       rsp_last;

   value_text_sb_type sb;
   int           cyc         = 0;
   int           n_accepted  = 0;
   int           n_popped    = 0;
   int           full_stalls = 0;
   bit           tx_steady   = 1'b0;

   int64_to_decimal_ascii_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_value     (req_value),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   // clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc == CYC_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // watch both handshakes; values sampled here are the ones the core saw
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            sb.note_value(req_value);
            n_accepted++;
         end
         if (req_push && req_full)
            full_stalls++;
         if (rsp_pop && !rsp_empty) begin
            sb.check_char(rsp_char_code, rsp_last, $time);
            n_popped++;
         end
      end
   end

   // response side: random pops, one long hold-off, one stretch of steady pops
   initial begin : rsp_side
      int hold_left;
      bit held;
      hold_left = 0;
      held      = 1'b0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_pop <= 1'b0;
            hold_left--;
         end else if (!held && n_accepted >= 60) begin
            // long hold-off so the queue fills and the input stalls
            held      = 1'b1;
            hold_left = HOLD_CYCS - 1;
            rsp_pop <= 1'b0;
         end else if (n_popped >= 2000 && n_popped < 2800) begin
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= 32);
         end
      end
   end

   // offer one integer word, with optional random idle cycles ahead of it
   task automatic send_value(logic [IN_BITS-1:0] v);
      while (!tx_steady && $urandom_range(0, 99) < 32) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push  <= 1'b1;
      req_value <= v;
      forever begin
         @(posedge clock);
         if (!req_full) break;
      end
   endtask

   // pick a random integer: long ones, short ones, near powers of ten, extremes
   function automatic logic [IN_BITS-1:0] random_value();
      int                   kind;
      int                   nb;
      int                   p;
      logic signed [63:0]   v;
      kind = $urandom_range(0, 9);
      v    = {$urandom, $urandom};
      if (kind <= 3) begin
         return v;
      end else if (kind <= 6) begin
         nb = $urandom_range(1, 63);
         v  = v & ((64'sd1 <<< nb) - 64'sd1);
      end else if (kind <= 8) begin
         p = $urandom_range(0, 18);
         v = 64'sd1;
         repeat (p) v = v * 64'sd10;
         v = v + $signed(64'($urandom_range(0, 2))) - 64'sd1;
      end else begin
         case ($urandom_range(0, 3))
            0:       v = 64'h7FFF_FFFF_FFFF_FFFF;
            1:       v = 64'h8000_0000_0000_0000;
            2:       v = 64'sd0;
            default: v = -64'sd1;
         endcase
         return v;
      end
      if ($urandom_range(0, 1) == 1)
         v = -v;
      return v;
   endfunction

   // main sequence
   initial begin : req_side
      logic [IN_BITS-1:0] corners[$];
      sb = new();
      req_push  <= 1'b0;
      req_value <= '0;
      corners = '{
         64'sd0, 64'sd1, -64'sd1, 64'sd9, -64'sd9, 64'sd10, -64'sd10, 64'sd99, 64'sd100,
         64'sd999999999999999999, 64'sd1000000000000000000, -64'sd1000000000000000000,
         64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
         64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'sd1234567890123456789,
         -64'sd1234567890123456789, 64'sd4294967296
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner integers
      foreach (corners[i])
         send_value(corners[i]);

      // shaped random integers
      for (int i = 0; i < N_RANDOM; i++) begin
         tx_steady = (i >= 100 && i < 160);
         if (i == 180) begin
            // drain everything before carrying on; the wait on the clock lets the monitor note the last word
            req_push <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
         end
         send_value(random_value());
      end
      req_push <= 1'b0;
      @(posedge clock);

      // let the last characters out, then allow for the back end latency
      while (sb.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("tb: %0d integers converted, %0d character words checked",
               sb.values_seen, sb.chars_checked);
      $display("tb: input held off by a full queue for %0d cycles", full_stalls);
      if (sb.pending() != 0)
         $display("%0t: %0d expected characters never arrived", $time, sb.pending());
      if (sb.faults == 0 && sb.pending() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

FILE: files.f
hdl/i64dec_pkg.sv
hdl/i64dec_front.sv
hdl/i64dec_queue.sv
hdl/i64dec_back.sv
hdl/int64_to_decimal_ascii_core.sv
tb/sv/i64dec_text_sb_pkg.sv
tb/sv/tb.sv
